// ===== hw/rtl/ias_pkg.sv =====
// ias_pkg: shared types and constants for the integer array sorter.
// Used by ias_cell, integer_array_sorter_top and tb. No dependencies.

package ias_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [CNT_W-1:0]             count_type;

   typedef struct packed {
      data_type value;
      logic     last;
   } req_type;

   typedef struct packed {
      data_type sorted_value;
      logic     last_out;
      logic     overflow;
   } rsp_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/ias_cell.sv =====
// ias_cell: one slot of the insertion sort chain.
// Depends on ias_pkg. Holds one value; shifts up on insert, down on drain.

module ias_cell
   import ias_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  data_type     new_value,
   input  logic         occupied,
   input  logic         prev_shift,
   input  data_type     prev_value,
   input  data_type     next_value,
   output data_type     value,
   output logic         shift
);

   data_type value_ff;
   data_type value_in;

   // an empty slot or a larger value makes room for the new one
   assign shift = !occupied || (new_value < value_ff);

   always_comb begin
      value_in = value_ff;
      if (ctl.insert && shift) begin
         value_in = prev_shift ? prev_value : new_value;
      end else if (ctl.drain) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== hw/rtl/integer_array_sorter_top.sv =====
// integer_array_sorter_top: streaming ascending sorter built from a chain of ias_cell.
// Depends on ias_pkg and ias_cell.
//
//  channel  ports                    handshake
//  input    start, busy, req_data    beat taken when start && !busy
//  result   rsp_strobe, rsp_data     one strobe per beat, no back-pressure
//
// An element is inserted into the sorted cell chain in the cycle it is taken.
// A beat marked last starts the drain: busy stays high until the set is drained,
// and cell 0 is shifted out one value per cycle into the output register, so
// each of the n results of a set appears in the cycle after its value leaves
// cell 0. Elements beyond DEPTH are dropped.
// Reset clears the count, overflow flag, drain state and result strobe; cell contents
// and the result register are not reset. The receiver cannot stall.

module integer_array_sorter_top
   import ias_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic      cnt_full;
   logic      accept;
   count_type cnt_ff,      cnt_in;
   logic      overflow_ff, overflow_in;
   logic      drain_ff,    drain_in;
   logic      rsp_strobe_ff, rsp_strobe_in;
   rsp_type   rsp_ff,      rsp_in;

   cell_ctl_type ctl;
   data_type     cell_value [DEPTH];
   logic         cell_shift [DEPTH];

   assign accept   = start && !drain_ff;
   assign cnt_full = (cnt_ff == count_type'(DEPTH));

   assign ctl.insert = accept && !cnt_full;
   assign ctl.drain  = drain_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic     occ;
      logic     p_shift;
      data_type p_value;
      data_type n_value;

      assign occ = count_type'(i) < cnt_ff;

      if (i == 0) begin : g_head
         assign p_shift = 1'b0;
         assign p_value = req_data.value;
      end else begin : g_body
         assign p_shift = cell_shift[i-1];
         assign p_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign n_value = '0;
      end else begin : g_mid
         assign n_value = cell_value[i+1];
      end

      ias_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_value  (req_data.value),
         .occupied   (occ),
         .prev_shift (p_shift),
         .prev_value (p_value),
         .next_value (n_value),
         .value      (cell_value[i]),
         .shift      (cell_shift[i])
      );
   end

   always_comb begin
      cnt_in        = cnt_ff;
      overflow_in   = overflow_ff;
      drain_in      = drain_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      if (drain_ff) begin
         rsp_strobe_in       = 1'b1;
         rsp_in.sorted_value = cell_value[0];
         rsp_in.last_out     = (cnt_ff == count_type'(1));
         rsp_in.overflow     = overflow_ff;
         cnt_in              = cnt_ff - count_type'(1);
         if (cnt_ff == count_type'(1)) begin
            drain_in    = 1'b0;
            overflow_in = 1'b0;
         end
      end else if (accept) begin
         if (cnt_full) begin
            overflow_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + count_type'(1);
         end
         drain_in = req_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         overflow_ff   <= 1'b0;
         drain_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         overflow_ff   <= overflow_in;
         drain_ff      <= drain_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = drain_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= count_type'(DEPTH))
      else $error("element count beyond capacity");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_out |-> !busy)
      else $error("still busy after final result");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_out |-> busy)
      else $error("drain stopped before final result");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.last |=> busy && cnt_ff != '0)
      else $error("set end did not start a drain");

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for integer_array_sorter_top (ascending set sorter).
// Depends on ias_pkg and the sorter RTL. Directed table first, then random sets
// with overflow cases, checked beat by beat against a local sort model or a row's want.

module tb;
   import ias_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 345;

   typedef struct {
      req_type beat;
      bit      typed;   // want holds the result of a one-element set
      rsp_type want;
   } directed_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // sort model state: kept values held in ascending order
   data_type held_values[$];
   bit       dropped_seen;
   rsp_type  fresh_results[$];
   rsp_type  sorted_pending[$];

   // beat on the request port, seen by the monitor at the accepting edge
   bit      cur_typed;
   rsp_type cur_want;
   bit      idle_on;

   int unsigned cycle_count  = 0;
   int unsigned error_count  = 0;
   int unsigned items_sent   = 0;
   int unsigned sets_done    = 0;
   int unsigned ovf_sets     = 0;
   int unsigned results_seen = 0;

   directed_row_type directed_rows [0:12] = '{
      '{'{32'sh7fffffff, 1'b1}, 1'b1, '{32'sh7fffffff, 1'b1, 1'b0}},
      '{'{32'sh80000000, 1'b1}, 1'b1, '{32'sh80000000, 1'b1, 1'b0}},
      '{'{32'sh00000000, 1'b1}, 1'b1, '{32'sh00000000, 1'b1, 1'b0}},
      '{'{32'shffffffff, 1'b1}, 1'b1, '{32'shffffffff, 1'b1, 1'b0}},
      '{'{32'sh00000005, 1'b0}, 1'b0, '{32'sh0, 1'b0, 1'b0}},
      '{'{-32'sd5,       1'b1}, 1'b0, '{32'sh0, 1'b0, 1'b0}},
      '{'{32'sh00000007, 1'b0}, 1'b0, '{32'sh0, 1'b0, 1'b0}},
      '{'{32'sh00000007, 1'b0}, 1'b0, '{32'sh0, 1'b0, 1'b0}},
      '{'{32'sh00000007, 1'b1}, 1'b0, '{32'sh0, 1'b0, 1'b0}},
      '{'{32'sh7fffffff, 1'b0}, 1'b0, '{32'sh0, 1'b0, 1'b0}},
      '{'{32'sh80000000, 1'b0}, 1'b0, '{32'sh0, 1'b0, 1'b0}},
      '{'{32'sh00000000, 1'b0}, 1'b0, '{32'sh0, 1'b0, 1'b0}},
      '{'{32'shffffffff, 1'b1}, 1'b0, '{32'sh0, 1'b0, 1'b0}}
   };

   integer_array_sorter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Take one accepted beat into the sort model; a set end fills fresh_results.
   function automatic void sort_model_take(input req_type beat);
      int pos;
      fresh_results.delete();
      if (held_values.size() < DEPTH) begin
         pos = 0;
         while (pos < held_values.size() && !(beat.value < held_values[pos]))
            pos++;
         held_values.insert(pos, beat.value);
      end else begin
         dropped_seen = 1'b1;
      end
      if (beat.last) begin
         foreach (held_values[k])
            fresh_results.push_back('{held_values[k], k == held_values.size() - 1,
                                      dropped_seen});
         held_values.delete();
         dropped_seen = 1'b0;
      end
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (sorted_pending.size() == 0) begin
         report_mismatch($sformatf("unexpected beat value=%0d last=%0b ovf=%0b",
                                   got.sorted_value, got.last_out, got.overflow));
         return;
      end
      want = sorted_pending.pop_front();
      if (got.sorted_value !== want.sorted_value)
         report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                   got.sorted_value, want.sorted_value));
      if (got.last_out !== want.last_out)
         report_mismatch($sformatf("last_out %0b, expected %0b (value %0d)",
                                   got.last_out, want.last_out, want.sorted_value));
      if (got.overflow !== want.overflow)
         report_mismatch($sformatf("overflow %0b, expected %0b (value %0d)",
                                   got.overflow, want.overflow, want.sorted_value));
   endtask

   // results first so a beat ending a set never lands ahead of older ones
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            check_result(rsp_data);
         if (start && !busy) begin
            sort_model_take(req_data);
            if (req_data.last) begin
               sets_done++;
               if (fresh_results.size() > 0 && fresh_results[0].overflow)
                  ovf_sets++;
               if (cur_typed)
                  sorted_pending.push_back(cur_want);
               else
                  foreach (fresh_results[k])
                     sorted_pending.push_back(fresh_results[k]);
            end
         end
      end
   end

   // Called just after a falling edge; returns just after the falling edge that
   // follows acceptance. start is left high for a back-to-back beat.
   task automatic drive_beat(input req_type beat, input bit typed, input rsp_type want);
      while (idle_on && $urandom_range(0, 99) < 15) begin
         start = 1'b0;
         @(negedge clock);
      end
      start     = 1'b1;
      req_data  = beat;
      cur_typed = typed;
      cur_want  = want;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic data_type pick_value(input int style);
      case (style)
         0: return data_type'($urandom);
         1: return data_type'($signed($urandom_range(0, 8)) - 4);
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return data_type'($urandom_range(0, 2)) - 1;
               default: return data_type'($urandom);
            endcase
         end
      endcase
   endfunction

   initial begin
      rsp_type  no_want;
      req_type  beat;
      int       set_len;
      int       style;
      int       pick;
      int       random_sets;

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      cur_typed = 1'b0;
      cur_want  = '0;
      no_want   = '0;
      idle_on   = 1'b1;
      dropped_seen = 1'b0;
      random_sets  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r])
         drive_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);

      // random sets; the first one overflows and its marked beat is dropped
      while (items_sent < $size(directed_rows) + RANDOM_ITEMS) begin
         idle_on = !(random_sets >= 8 && random_sets < 16);
         pick = $urandom_range(0, 99);
         if (random_sets == 0)
            set_len = DEPTH + 1;
         else if (pick < 15)
            set_len = $urandom_range(DEPTH + 1, DEPTH + 5);
         else if (pick < 35)
            set_len = DEPTH;
         else if (pick < 55)
            set_len = $urandom_range(1, 3);
         else
            set_len = $urandom_range(4, DEPTH - 1);
         style = $urandom_range(0, 2);
         for (int i = 0; i < set_len; i++) begin
            beat.value = pick_value(style);
            beat.last  = (i == set_len - 1);
            drive_beat(beat, 1'b0, no_want);
         end
         random_sets++;
      end
      start = 1'b0;

      while (sorted_pending.size() != 0)
         @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);

      if (sorted_pending.size() != 0)
         report_mismatch($sformatf("%0d expected beats never arrived",
                                   sorted_pending.size()));
      $display("covered %0d input beats in %0d sets (%0d with dropped elements)",
               items_sent, sets_done, ovf_sets);
      $display("checked %0d sorted beats, %0d mismatches", results_seen, error_count);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
